// ===== hw/rtl/amc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the accumulator machine core.
// Used by every module under hw/rtl; depends on nothing.
package amc_pkg;

  localparam int WORD_BITS = 32;
  localparam int MEM_WORDS = 100;
  localparam int ADDR_W    = 7;
  localparam int OP_W      = 6;
  localparam int CNT_W     = $clog2(WORD_BITS);

  // Decode by reciprocal: words of interest stay below 4400 (opcode 43, address 99).
  localparam int DEC_LIMIT = 4400;
  localparam int DEC_W     = 13;
  localparam int RECIP     = 5243;
  localparam int RECIP_SH  = 19;
  localparam int RADIX     = 100;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [OP_W-1:0]      op_t;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_EXEC    = 2'd1,
    REQ_READ    = 2'd2,
    REQ_RESTART = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_HALTED   = 2'd1,
    ST_DIVZ     = 2'd2,
    ST_PC_RANGE = 2'd3
  } status_t;

  localparam op_t OP_NONE   = 6'd0;
  localparam op_t OP_READ   = 6'd10;
  localparam op_t OP_WRITE  = 6'd11;
  localparam op_t OP_LOAD   = 6'd20;
  localparam op_t OP_STORE  = 6'd21;
  localparam op_t OP_ADD    = 6'd30;
  localparam op_t OP_SUB    = 6'd31;
  localparam op_t OP_DIV    = 6'd32;
  localparam op_t OP_MUL    = 6'd33;
  localparam op_t OP_INC    = 6'd34;
  localparam op_t OP_BR     = 6'd40;
  localparam op_t OP_BRNEG  = 6'd41;
  localparam op_t OP_BRZERO = 6'd42;
  localparam op_t OP_HALT   = 6'd43;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_RDW, S_DEC, S_OPND, S_EXEC, S_MD, S_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic start;
    logic rdw;
    logic decode;
    logic opnd;
    logic exec;
    logic md_upd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic halted;
    logic pc_oob;
    logic md_go;
    logic md_done;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== hw/rtl/amc_muldiv.sv =====
`timescale 1ns / 1ps
// Iterative multiply / signed divide, one bit per cycle.
// Depends on amc_pkg.
module amc_muldiv import amc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  logic  is_div,
  input  word_t opa,
  input  word_t opb,
  output logic  done,
  output word_t result
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic               div_r, div_nxt;
  logic               neg_r, neg_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  word_t              prod_r, prod_nxt;
  word_t              shq_r, shq_nxt;
  word_t              opb_r, opb_nxt;
  logic [WORD_BITS:0] rem_r, rem_nxt;
  logic [WORD_BITS:0] rem_sh, diff;
  word_t              mag_a, mag_b;

  always_comb begin
    mag_a  = opa[WORD_BITS-1] ? (~opa + 1'b1) : opa;
    mag_b  = opb[WORD_BITS-1] ? (~opb + 1'b1) : opb;
    rem_sh = {rem_r[WORD_BITS-1:0], shq_r[WORD_BITS-1]};
    diff   = rem_sh - {1'b0, opb_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    prod_nxt = prod_r;
    shq_nxt  = shq_r;
    opb_nxt  = opb_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      div_nxt  = is_div;
      neg_nxt  = opa[WORD_BITS-1] ^ opb[WORD_BITS-1];
      cnt_nxt  = '0;
      prod_nxt = '0;
      rem_nxt  = '0;
      shq_nxt  = is_div ? mag_a : opb;
      opb_nxt  = is_div ? mag_b : opa;
    end else if (busy_r) begin
      if (div_r) begin
        if (!diff[WORD_BITS]) begin
          rem_nxt = diff;
          shq_nxt = {shq_r[WORD_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          shq_nxt = {shq_r[WORD_BITS-2:0], 1'b0};
        end
      end else begin
        if (shq_r[0]) prod_nxt = prod_r + opb_r;
        opb_nxt = {opb_r[WORD_BITS-2:0], 1'b0};
        shq_nxt = {1'b0, shq_r[WORD_BITS-1:1]};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(WORD_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    div_r  <= div_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
    prod_r <= prod_nxt;
    shq_r  <= shq_nxt;
    opb_r  <= opb_nxt;
    rem_r  <= rem_nxt;
  end

  assign done   = done_r;
  assign result = div_r ? (neg_r ? (~shq_r + 1'b1) : shq_r) : prod_r;

endmodule

// ===== hw/rtl/amc_dp.sv =====
`timescale 1ns / 1ps
// Datapath: word memory, accumulator, pc, decode, execute and result register.
// Depends on amc_pkg and amc_muldiv.
module amc_dp import amc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output dp_status_t         st,
  input  logic [1:0]         in_req_type,
  input  logic [ADDR_W-1:0]  in_mem_address,
  input  logic signed [31:0] in_data_word,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic               out_out_valid,
  output logic signed [31:0] out_out_value,
  output logic               out_input_used,
  output logic signed [31:0] out_read_word,
  output logic signed [31:0] out_acc_value,
  output logic [ADDR_W-1:0]  out_pc_value
);

  word_t               mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] mem_vld_r;

  req_t              req_r;
  logic [ADDR_W-1:0] addr_r;
  word_t             data_r;
  word_t             acc_r;
  logic [ADDR_W-1:0] pc_r;
  logic              halted_r;
  word_t             rdata_r;
  logic              rd_ok_r;
  op_t               op_r;
  logic [ADDR_W-1:0] a_r;
  status_t           status_r;
  logic              ov_r, iu_r;
  word_t             oval_r, rw_r;

  logic              out_vld_r;
  logic [1:0]        o_status_r;
  logic              o_ov_r, o_iu_r;
  word_t             o_oval_r, o_rw_r, o_acc_r;
  logic [ADDR_W-1:0] o_pc_r;

  logic [ADDR_W-1:0] rd_addr;
  word_t             mem_q, mag;
  logic [DEC_W-1:0]  dec_lo, rem13;
  logic [2*DEC_W-1:0] prod;
  op_t               q_op;
  logic              in_rng;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  word_t             wdata;
  logic              md_go, md_done;
  word_t             md_res;

  assign mem_q = rd_ok_r ? rdata_r : '0;

  // Decode the fetched word into opcode and address.
  always_comb begin
    mag    = mem_q[WORD_BITS-1] ? (~mem_q + 1'b1) : mem_q;
    in_rng = !mem_q[WORD_BITS-1] && (mag < word_t'(DEC_LIMIT));
    dec_lo = mag[DEC_W-1:0];
    prod   = (2*DEC_W)'(dec_lo) * (2*DEC_W)'(RECIP);
    q_op   = prod[RECIP_SH+OP_W-1:RECIP_SH];
    rem13  = dec_lo - DEC_W'(q_op) * DEC_W'(RADIX);
  end

  always_comb begin
    if (cmd.opnd)               rd_addr = a_r;
    else if (req_r == REQ_READ) rd_addr = addr_r;
    else                        rd_addr = pc_r;
  end

  assign md_go = (op_r == OP_MUL) || ((op_r == OP_DIV) && (mem_q != '0));

  always_comb begin
    we    = 1'b0;
    waddr = a_r;
    wdata = data_r;
    if (cmd.start && req_r == REQ_LOAD && addr_r < ADDR_W'(MEM_WORDS)) begin
      we    = 1'b1;
      waddr = addr_r;
    end else if (cmd.exec && op_r == OP_READ) begin
      we = 1'b1;
    end else if (cmd.exec && op_r == OP_STORE) begin
      we    = 1'b1;
      wdata = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r <= '0;
      rd_ok_r   <= 1'b0;
    end else begin
      if (we) mem_vld_r[waddr] <= 1'b1;
      rd_ok_r <= (rd_addr < ADDR_W'(MEM_WORDS)) ? mem_vld_r[rd_addr] : 1'b0;
    end
  end

  amc_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.exec && md_go),
    .is_div (op_r == OP_DIV),
    .opa    (acc_r),
    .opb    (mem_q),
    .done   (md_done),
    .result (md_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      pc_r     <= '0;
      halted_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        unique case (req_r)
          REQ_RESTART: begin
            acc_r    <= '0;
            pc_r     <= '0;
            halted_r <= 1'b0;
          end
          REQ_EXEC: if (!halted_r && pc_r >= ADDR_W'(MEM_WORDS)) halted_r <= 1'b1;
          default: ;
        endcase
      end
      if (cmd.decode) pc_r <= pc_r + 1'b1;
      if (cmd.exec) begin
        case (op_r)
          OP_LOAD:    acc_r <= mem_q;
          OP_ADD:     acc_r <= acc_r + mem_q;
          OP_SUB:     acc_r <= acc_r - mem_q;
          OP_INC:     acc_r <= acc_r + 1'b1;
          OP_DIV:     if (mem_q == '0) halted_r <= 1'b1;
          OP_BR:      pc_r <= a_r;
          OP_BRNEG:   if (acc_r[WORD_BITS-1]) pc_r <= a_r;
          OP_BRZERO:  if (acc_r == '0) pc_r <= a_r;
          OP_HALT:    halted_r <= 1'b1;
          default: ;
        endcase
      end
      if (cmd.md_upd) acc_r <= md_res;
    end
  end

  // Per-item registers; no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r  <= req_t'(in_req_type);
      addr_r <= in_mem_address;
      data_r <= word_t'(in_data_word);
    end
    if (cmd.start) begin
      ov_r     <= 1'b0;
      iu_r     <= 1'b0;
      oval_r   <= '0;
      rw_r     <= '0;
      if (req_r == REQ_RESTART) status_r <= ST_OK;
      else if (req_r == REQ_EXEC && !halted_r && pc_r >= ADDR_W'(MEM_WORDS))
        status_r <= ST_PC_RANGE;
      else status_r <= halted_r ? ST_HALTED : ST_OK;
    end
    if (cmd.rdw) rw_r <= mem_q;
    if (cmd.decode) begin
      op_r <= in_rng ? q_op : OP_NONE;
      a_r  <= rem13[ADDR_W-1:0];
    end
    if (cmd.exec) begin
      case (op_r)
        OP_READ:  iu_r <= 1'b1;
        OP_WRITE: begin
          ov_r   <= 1'b1;
          oval_r <= mem_q;
        end
        OP_DIV:   if (mem_q == '0) status_r <= ST_DIVZ;
        OP_HALT:  status_r <= ST_HALTED;
        default: ;
      endcase
    end
    if (cmd.emit) begin
      o_status_r <= status_r;
      o_ov_r     <= ov_r;
      o_oval_r   <= oval_r;
      o_iu_r     <= iu_r;
      o_rw_r     <= rw_r;
      o_acc_r    <= acc_r;
      o_pc_r     <= pc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)        out_vld_r <= 1'b0;
    else if (cmd.emit) out_vld_r <= 1'b1;
    else if (!out_stall) out_vld_r <= 1'b0;
  end

  assign st.req      = req_r;
  assign st.halted   = halted_r;
  assign st.pc_oob   = pc_r >= ADDR_W'(MEM_WORDS);
  assign st.md_go    = md_go;
  assign st.md_done  = md_done;
  assign st.out_busy = out_vld_r && out_stall;

  assign out_valid      = out_vld_r;
  assign out_status     = o_status_r;
  assign out_out_valid  = o_ov_r;
  assign out_out_value  = o_oval_r;
  assign out_input_used = o_iu_r;
  assign out_read_word  = o_rw_r;
  assign out_acc_value  = o_acc_r;
  assign out_pc_value   = o_pc_r;

endmodule

// ===== hw/rtl/amc_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences one request through the datapath.
// Depends on amc_pkg.
module amc_ctrl import amc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t st,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_START;
      S_START: begin
        unique case (st.req)
          REQ_READ: state_nxt = S_RDW;
          REQ_EXEC: state_nxt = (st.halted || st.pc_oob) ? S_DONE : S_DEC;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_RDW:   state_nxt = S_DONE;
      S_DEC:   state_nxt = S_OPND;
      S_OPND:  state_nxt = S_EXEC;
      S_EXEC:  state_nxt = st.md_go ? S_MD : S_DONE;
      S_MD:    if (st.md_done) state_nxt = S_DONE;
      S_DONE:  if (!st.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
      end
      S_START: cmd.start  = 1'b1;
      S_RDW:   cmd.rdw    = 1'b1;
      S_DEC:   cmd.decode = 1'b1;
      S_OPND:  cmd.opnd   = 1'b1;
      S_EXEC:  cmd.exec   = 1'b1;
      S_MD:    cmd.md_upd = st.md_done;
      S_DONE:  cmd.emit   = !st.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== hw/rtl/accumulator_machine_core.sv =====
`timescale 1ns / 1ps
// Top level of the decimal accumulator machine: controller plus datapath.
// Depends on amc_pkg, amc_ctrl, amc_dp (which holds amc_muldiv).
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request beat: load a
//   memory word, execute one instruction, read a memory word back, or
//   restart pc/accumulator/halt flag. Every request yields exactly one
//   result beat on the output channel (out_valid / out_stall).
//   Each request steps through controller states: load and restart go
//   from start to done; read adds a read-word state; execute adds decode,
//   operand and execute states (none while halted or with pc out of range),
//   and multiply and divide wait in a state for the bit-serial shift-add /
//   restoring divide unit. One request is worked at a time; in_stall is low
//   only while the controller is idle.
//   The result register frees the core: a new request
//   is taken while the previous result still waits on out_stall, and the
//   core holds its next result in its final state until the register drains.
//   Reset (rst_n low, synchronous) clears pc, accumulator, halt flag, the
//   per-word valid bits (memory reads as zero until written) and both
//   handshakes; no clearing pass is needed.
module accumulator_machine_core import amc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [6:0]         in_mem_address,
  input  logic signed [31:0] in_data_word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic               out_out_valid,
  output logic signed [31:0] out_out_value,
  output logic               out_input_used,
  output logic signed [31:0] out_read_word,
  output logic signed [31:0] out_acc_value,
  output logic [6:0]         out_pc_value
);

  cmd_t       cmd;
  dp_status_t st;

  amc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  amc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_req_type    (in_req_type),
    .in_mem_address (in_mem_address),
    .in_data_word   (in_data_word),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_out_valid  (out_out_valid),
    .out_out_value  (out_out_value),
    .out_input_used (out_input_used),
    .out_read_word  (out_read_word),
    .out_acc_value  (out_acc_value),
    .out_pc_value   (out_pc_value)
  );

  // One request in flight: after an accept the input side must stall.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in flight");

  // The result register is loaded only when it is free or draining.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !st.out_busy)
    else $error("result overwritten while stalled");

  // The pc never runs past one beyond the last word.
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pc_value <= 7'd100))
    else $error("pc out of range in result");

  // A divide-by-zero result carries no write or read side effect flags.
  a_divz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_DIVZ) |-> (!out_out_valid && !out_input_used))
    else $error("divide error with side effects");

endmodule
